// ===== src/ivc_pkg.sv =====
// Shared types and constants for the irrigation valve controller.
// Used by ivc_step, irrigation_valve_controller, ivc_checker and the testbench; no other dependencies.
`timescale 1ns / 1ps

package ivc_pkg;

    localparam int DEFAULT_TIME_BITS = 32;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOISTURE_SETPOINT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FROST_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DAILY_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WATERING_SECONDS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_SECONDS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_INTERVAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_CHARGE      = 3'd6;

    // reset values of the configuration registers
    localparam logic [6:0]  RST_MOISTURE_SETPOINT = 7'd0;
    localparam logic [7:0]  RST_FROST_LIMIT       = 8'd10;
    localparam logic [7:0]  RST_DAILY_LIMIT       = 8'd15;
    localparam logic [15:0] RST_WATERING_SECONDS  = 16'd180;
    localparam logic [15:0] RST_HOLDOFF_SECONDS   = 16'd3600;
    localparam logic [15:0] RST_MEASURE_INTERVAL  = 16'd60;
    localparam logic [3:0]  RST_WATER_CHARGE      = 4'd3;

    localparam logic [6:0] THR_MIN          = 7'd45;
    localparam logic [6:0] THR_MAX          = 7'd95;
    localparam logic [8:0] TALLY_MAX        = 9'd511;
    localparam logic [5:0] LAST_MINUTE_INIT = 6'd60;

    typedef struct packed {
        logic [3:0]  water_charge;
        logic [15:0] measure_interval;
        logic [15:0] holdoff_seconds;
        logic [15:0] watering_seconds;
        logic [7:0]  daily_limit;
        logic [7:0]  frost_limit;       // two's complement, whole deg C
        logic [6:0]  moisture_setpoint;
    } cfg_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic        arm_press;
        logic        bypass_press;
        logic [11:0] temperature_tenths;
        logic [9:0]  humidity_tenths;
        logic [5:0]  minute_of_hour;
        logic [4:0]  day_of_month;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic       threshold_invalid;
        logic [8:0] water_used_today;
        logic       limit_exceeded;
        logic       valve_shut;
        logic       valve_opened;
        logic       cold_warning;
        logic       hourly_log;
        logic       measured;
        logic       bypass_led;
        logic       armed_led;
        logic       valve_drive;
    } result_t;

    typedef struct packed {
        logic       armed;
        logic       bypass;
        logic       valve;
        logic       indicator;
        logic [8:0] water_used;
        logic [4:0] current_day;
        logic [5:0] last_minute;
    } ctl_state_t;

endpackage

// ===== src/ivc_step.sv =====
// One controller tick: next state and result from the current state, config and item.
// Depends on ivc_pkg.
`timescale 1ns / 1ps

module ivc_step
    import ivc_pkg::*;
#(
    parameter int TIME_BITS = DEFAULT_TIME_BITS
)
(
    input  cfg_t                 cfg,
    input  item_t                item,
    input  ctl_state_t           st,
    input  logic [TIME_BITS-1:0] shut_dl,
    input  logic [TIME_BITS-1:0] meas_dl,
    input  logic [TIME_BITS-1:0] act_dl,
    output ctl_state_t           st_next,
    output logic [TIME_BITS-1:0] shut_dl_next,
    output logic [TIME_BITS-1:0] meas_dl_next,
    output logic [TIME_BITS-1:0] act_dl_next,
    output result_t              res
);

    logic [TIME_BITS-1:0] now_t;
    logic signed [12:0]   temp_ext;
    logic signed [12:0]   tlow_ext;
    logic signed [12:0]   tlow10;
    logic [10:0]          thr10;
    logic                 thr_ok;
    logic                 meas_passed;
    logic                 act_passed;
    logic                 temp_ok;
    logic                 hum_ok;
    logic [9:0]           water_sum;

    assign now_t       = TIME_BITS'(item.now_seconds);
    assign temp_ext    = 13'($signed(item.temperature_tenths));
    assign tlow_ext    = 13'($signed(cfg.frost_limit));
    assign tlow10      = (tlow_ext <<< 3) + (tlow_ext <<< 1);
    assign thr10       = ({4'b0, cfg.moisture_setpoint} << 3)
                       + ({4'b0, cfg.moisture_setpoint} << 1);
    assign thr_ok      = (cfg.moisture_setpoint >= THR_MIN)
                      && (cfg.moisture_setpoint <= THR_MAX);
    assign meas_passed = (meas_dl == '0) || (meas_dl < now_t);
    assign act_passed  = (act_dl == '0) || (act_dl < now_t);
    assign temp_ok     = !(temp_ext < tlow10);
    assign hum_ok      = {1'b0, item.humidity_tenths} <= thr10;

    always_comb
    begin
        st_next      = st;
        shut_dl_next = shut_dl;
        meas_dl_next = meas_dl;
        act_dl_next  = act_dl;
        res          = '0;
        water_sum    = '0;

        // bypass button: press while open cancels, else toggles and opens when bypass turns on
        if (item.bypass_press)
        begin
            st_next.bypass    = st.valve ? 1'b0 : !st.bypass;
            st_next.indicator = st_next.bypass;
            if (st_next.bypass && !st.valve)
            begin
                st_next.valve = 1'b1;
                st_next.armed = 1'b1;
                shut_dl_next  = now_t + TIME_BITS'(cfg.watering_seconds);
            end
            if (!st_next.bypass && st.valve)
            begin
                shut_dl_next = now_t;
            end
        end
        if (item.arm_press)
        begin
            st_next.armed = !st_next.armed;
        end

        // new day clears the tally; unknown day just loads
        if ((st.current_day != '0) && (st.current_day != item.day_of_month))
        begin
            st_next.water_used = '0;
        end
        st_next.current_day = item.day_of_month;

        if (meas_passed)
        begin
            res.measured     = 1'b1;
            res.hourly_log   = st.last_minute > item.minute_of_hour;
            res.cold_warning = res.hourly_log && !temp_ok;
            if (st_next.armed && act_passed && temp_ok && thr_ok && hum_ok
                && (st_next.water_used < {1'b0, cfg.daily_limit}))
            begin
                act_dl_next       = now_t + TIME_BITS'(cfg.holdoff_seconds);
                shut_dl_next      = now_t + TIME_BITS'(cfg.watering_seconds);
                st_next.valve     = 1'b1;
                st_next.indicator = 1'b1;
                water_sum = {1'b0, st_next.water_used} + 10'(cfg.water_charge);
                st_next.water_used = water_sum[9] ? TALLY_MAX : water_sum[8:0];
                res.valve_opened = 1'b1;
            end
            meas_dl_next = now_t + TIME_BITS'(cfg.measure_interval);
        end

        if ((shut_dl_next != '0) && (shut_dl_next < now_t))
        begin
            shut_dl_next       = '0;
            st_next.indicator  = 1'b0;
            st_next.valve      = 1'b0;
            res.valve_shut     = 1'b1;
            res.limit_exceeded = st_next.water_used > {1'b0, cfg.daily_limit};
        end

        st_next.last_minute = item.minute_of_hour;

        res.valve_drive       = st_next.valve;
        res.armed_led         = st_next.armed;
        res.bypass_led        = st_next.indicator;
        res.water_used_today  = st_next.water_used;
        res.threshold_invalid = !thr_ok;
    end

endmodule

// ===== src/irrigation_valve_controller.sv =====
// Top level of the irrigation valve controller: stream ports, config registers, state.
// Depends on ivc_pkg and ivc_step.
`timescale 1ns / 1ps

// Usage:
//   One input beat on s_* is one controller tick (time, calendar, sensors, buttons).
//   Every tick produces exactly one result beat on m_* with the valve and
//   indicator levels, the event flags of that tick and the daily tally.
//   Configuration registers are written over cfg_* (cfg_ready is always high);
//   write them only while no tick is in flight.
//   After the input beat is taken, the tick passes through the input register
//   and then the result register before m_tvalid rises.
//   Throughput: one tick per cycle while m_tready is high; the whole tick is
//   evaluated in one pass of logic between the input register and the result
//   register, and the controller state updates in the same cycle.
//   When the receiver stalls, the finished result waits in the result
//   register while the next tick sits in the input register; s_tready drops
//   only once both are occupied and m_tready is low.
//   Reset: armed, valve closed, bypass off, all deadlines unset, tally zero,
//   day unknown, configuration at its default values.

module irrigation_valve_controller
    import ivc_pkg::*;
#(
    parameter int TIME_BITS = DEFAULT_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [31:0] now_seconds, [36:32] day_of_month, [42:37] minute_of_hour,
    // [52:43] humidity_tenths, [64:53] temperature_tenths, [65] bypass_press,
    // [66] arm_press, [71:67] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] valve_drive, [1] armed_led, [2] bypass_led, [3] measured, [4] hourly_log,
    // [5] cold_warning, [6] valve_opened, [7] valve_shut, [8] limit_exceeded,
    // [17:9] water_used_today, [18] threshold_invalid, [23:19] zero
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg_reg;
    item_t                in_item_reg;
    logic                 in_valid_reg;
    result_t              out_res_reg;
    logic                 out_valid_reg;
    ctl_state_t           st_reg;
    ctl_state_t           st_next;
    logic [TIME_BITS-1:0] shut_dl_reg;
    logic [TIME_BITS-1:0] shut_dl_next;
    logic [TIME_BITS-1:0] meas_dl_reg;
    logic [TIME_BITS-1:0] meas_dl_next;
    logic [TIME_BITS-1:0] act_dl_reg;
    logic [TIME_BITS-1:0] act_dl_next;
    result_t              res_next;
    logic                 advance;
    logic                 s_beat;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_beat    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_DATA_W - $bits(result_t))'(0), out_res_reg};
    assign cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.moisture_setpoint <= RST_MOISTURE_SETPOINT;
            cfg_reg.frost_limit       <= RST_FROST_LIMIT;
            cfg_reg.daily_limit       <= RST_DAILY_LIMIT;
            cfg_reg.watering_seconds  <= RST_WATERING_SECONDS;
            cfg_reg.holdoff_seconds   <= RST_HOLDOFF_SECONDS;
            cfg_reg.measure_interval  <= RST_MEASURE_INTERVAL;
            cfg_reg.water_charge      <= RST_WATER_CHARGE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MOISTURE_SETPOINT: cfg_reg.moisture_setpoint <= cfg_data[6:0];
                REG_FROST_LIMIT:       cfg_reg.frost_limit       <= cfg_data[7:0];
                REG_DAILY_LIMIT:       cfg_reg.daily_limit       <= cfg_data[7:0];
                REG_WATERING_SECONDS:  cfg_reg.watering_seconds  <= cfg_data;
                REG_HOLDOFF_SECONDS:   cfg_reg.holdoff_seconds   <= cfg_data;
                REG_MEASURE_INTERVAL:  cfg_reg.measure_interval  <= cfg_data;
                REG_WATER_CHARGE:      cfg_reg.water_charge      <= cfg_data[3:0];
                default:               ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

    ivc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .cfg          (cfg_reg),
        .item         (in_item_reg),
        .st           (st_reg),
        .shut_dl      (shut_dl_reg),
        .meas_dl      (meas_dl_reg),
        .act_dl       (act_dl_reg),
        .st_next      (st_next),
        .shut_dl_next (shut_dl_next),
        .meas_dl_next (meas_dl_next),
        .act_dl_next  (act_dl_next),
        .res          (res_next)
    );

    // controller state, updated once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.armed       <= 1'b1;
            st_reg.bypass      <= 1'b0;
            st_reg.valve       <= 1'b0;
            st_reg.indicator   <= 1'b0;
            st_reg.water_used  <= '0;
            st_reg.current_day <= '0;
            st_reg.last_minute <= LAST_MINUTE_INIT;
            shut_dl_reg        <= '0;
            meas_dl_reg        <= '0;
            act_dl_reg         <= '0;
        end
        else if (advance)
        begin
            st_reg      <= st_next;
            shut_dl_reg <= shut_dl_next;
            meas_dl_reg <= meas_dl_next;
            act_dl_reg  <= act_dl_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    // a shut beat always reports the valve closed
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.valve_shut |-> !out_res_reg.valve_drive)
        else $error("valve reported open on shut beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.limit_exceeded |-> out_res_reg.valve_shut)
        else $error("limit flag without shut");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.hourly_log || out_res_reg.valve_opened)
        |-> out_res_reg.measured)
        else $error("measurement event flag without measurement");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.cold_warning |-> out_res_reg.hourly_log)
        else $error("cold warning without hourly log");

    // state only moves when a tick is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(st_reg) && $stable(shut_dl_reg))
        else $error("state changed without a tick");

endmodule

// ===== tb/ivc_checker.sv =====
// Scoreboard for the irrigation valve controller: watches the tick, result and
// register-write channels, keeps its own copy of settings and controller state.
// Depends on ivc_pkg only.
`timescale 1ns / 1ps

module ivc_checker
    import ivc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    // settings as last written
    logic [6:0]  thr_c;
    logic [7:0]  tlow_c;
    logic [7:0]  limit_c;
    logic [15:0] water_secs_c;
    logic [15:0] holdoff_c;
    logic [15:0] interval_c;
    logic [3:0]  charge_c;

    // controller state
    logic        armed_q;
    logic        bypass_q;
    logic        valve_q;
    logic        lamp_q;
    logic [31:0] shut_at;
    logic [31:0] measure_at;
    logic [31:0] rearm_at;
    logic [8:0]  tally;
    logic [4:0]  day_q;
    logic [5:0]  minute_q;

    result_t expected_results[$];
    int      result_no;

    task automatic log_error(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            log_error($sformatf("result %0d: %s is %0d, expected %0d",
                                result_no, name, got, want));
    endtask

    task automatic restore_defaults();
        thr_c        = RST_MOISTURE_SETPOINT;
        tlow_c       = RST_FROST_LIMIT;
        limit_c      = RST_DAILY_LIMIT;
        water_secs_c = RST_WATERING_SECONDS;
        holdoff_c    = RST_HOLDOFF_SECONDS;
        interval_c   = RST_MEASURE_INTERVAL;
        charge_c     = RST_WATER_CHARGE;
        armed_q      = 1'b1;
        bypass_q     = 1'b0;
        valve_q      = 1'b0;
        lamp_q       = 1'b0;
        shut_at      = '0;
        measure_at   = '0;
        rearm_at     = '0;
        tally        = '0;
        day_q        = '0;
        minute_q     = LAST_MINUTE_INIT;
    endtask

    // zero means the deadline was never set
    function automatic logic deadline_due(input logic [31:0] dl, input logic [31:0] now);
        return (dl == 32'd0) || (dl < now);
    endfunction

    task automatic advance_controller(input item_t it, output result_t r);
        logic [31:0] now;
        int          temp_v;
        int          hum_v;
        int          cold_lim;
        int          sum;
        logic        thr_ok;
        logic        measured;
        logic        hourly;
        logic        cold;
        logic        opened;
        logic        shut;
        logic        over;

        now      = it.now_seconds;
        hum_v    = int'(it.humidity_tenths);
        temp_v   = int'($signed(it.temperature_tenths));
        cold_lim = int'($signed(tlow_c)) * 10;
        thr_ok   = (thr_c >= THR_MIN) && (thr_c <= THR_MAX);
        measured = 1'b0;
        hourly   = 1'b0;
        cold     = 1'b0;
        opened   = 1'b0;
        shut     = 1'b0;
        over     = 1'b0;

        if (it.bypass_press)
        begin
            bypass_q = valve_q ? 1'b0 : !bypass_q;
            lamp_q   = bypass_q;
            if (bypass_q && !valve_q)
            begin
                valve_q = 1'b1;
                armed_q = 1'b1;
                shut_at = now + 32'(water_secs_c);
            end
            // press while open: shut on a later, larger time
            if (!bypass_q && valve_q)
                shut_at = now;
        end
        if (it.arm_press)
            armed_q = !armed_q;

        if (day_q == 5'd0)
            day_q = it.day_of_month;
        if (day_q != it.day_of_month)
        begin
            tally = '0;
            day_q = it.day_of_month;
        end

        if (deadline_due(measure_at, now))
        begin
            measured = 1'b1;
            hourly   = minute_q > it.minute_of_hour;
            cold     = hourly && (temp_v < cold_lim);
            if (armed_q && deadline_due(rearm_at, now) && temp_v >= cold_lim &&
                int'(tally) < int'(limit_c) && thr_ok && hum_v <= int'(thr_c) * 10)
            begin
                rearm_at = now + 32'(holdoff_c);
                shut_at  = now + 32'(water_secs_c);
                valve_q  = 1'b1;
                lamp_q   = 1'b1;
                sum      = int'(tally) + int'(charge_c);
                tally    = (sum > int'(TALLY_MAX)) ? TALLY_MAX : 9'(sum);
                opened   = 1'b1;
            end
            measure_at = now + 32'(interval_c);
        end

        if (shut_at != 32'd0 && shut_at < now)
        begin
            shut_at = '0;
            lamp_q  = 1'b0;
            valve_q = 1'b0;
            shut    = 1'b1;
            over    = int'(tally) > int'(limit_c);
        end

        minute_q = it.minute_of_hour;

        r.valve_drive       = valve_q;
        r.armed_led         = armed_q;
        r.bypass_led        = lamp_q;
        r.measured          = measured;
        r.hourly_log        = hourly;
        r.cold_warning      = cold;
        r.valve_opened      = opened;
        r.valve_shut        = shut;
        r.limit_exceeded    = over;
        r.water_used_today  = tally;
        r.threshold_invalid = !thr_ok;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        item_t   it;
        result_t got;
        result_t want;

        if (!rst_n)
        begin
            restore_defaults();
            expected_results.delete();
            result_no  = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MOISTURE_SETPOINT: thr_c        = cfg_data[6:0];
                    REG_FROST_LIMIT:       tlow_c       = cfg_data[7:0];
                    REG_DAILY_LIMIT:       limit_c      = cfg_data[7:0];
                    REG_WATERING_SECONDS:  water_secs_c = cfg_data;
                    REG_HOLDOFF_SECONDS:   holdoff_c    = cfg_data;
                    REG_MEASURE_INTERVAL:  interval_c   = cfg_data;
                    REG_WATER_CHARGE:      charge_c     = cfg_data[3:0];
                    default: ;
                endcase
            end
            // drain before filling: a result never belongs to the tick of its own beat
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_results.size() == 0)
                begin
                    log_error($sformatf("result %0d arrived with no tick pending", result_no));
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("valve_drive", got.valve_drive, want.valve_drive);
                    check_field("armed_led", got.armed_led, want.armed_led);
                    check_field("bypass_led", got.bypass_led, want.bypass_led);
                    check_field("measured", got.measured, want.measured);
                    check_field("hourly_log", got.hourly_log, want.hourly_log);
                    check_field("cold_warning", got.cold_warning, want.cold_warning);
                    check_field("valve_opened", got.valve_opened, want.valve_opened);
                    check_field("valve_shut", got.valve_shut, want.valve_shut);
                    check_field("limit_exceeded", got.limit_exceeded, want.limit_exceeded);
                    check_field("water_used_today", got.water_used_today,
                                want.water_used_today);
                    check_field("threshold_invalid", got.threshold_invalid,
                                want.threshold_invalid);
                end
                result_no++;
            end
            if (s_tvalid && s_tready)
            begin
                it = s_tdata[$bits(item_t)-1:0];
                advance_controller(it, want);
                expected_results.push_back(want);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== tb/tb_irrigation_valve_controller.sv =====
// Top of the irrigation valve controller regression: clock, reset, tick and
// register-write stimulus, result back-pressure, watchdog and verdict.
// Depends on ivc_pkg, irrigation_valve_controller and ivc_checker.
`timescale 1ns / 1ps

module tb_irrigation_valve_controller
    import ivc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 500;
    localparam int PHASE_TICKS    = 54;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;

    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          ready_mode  = 0;
    int          ready_hold  = 0;
    int          ready_phase = 0;
    logic [31:0] clock_now   = 32'd0;
    logic [4:0]  clock_day   = 5'd1;

    always #6 clk = ~clk;

    irrigation_valve_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ivc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: switches between always-ready, random, periodic and mostly-stalled
    always @(posedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(16, 64);
        end
        else
        begin
            ready_hold = ready_hold - 1;
        end
        ready_phase = (ready_phase + 1) % 7;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (ready_phase < 4);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic item_t make_item(input logic [31:0] now, input logic [4:0] day,
                                        input logic [5:0] minute, input logic [9:0] hum,
                                        input int temp, input logic bp, input logic ap);
        item_t it;
        it.now_seconds        = now;
        it.day_of_month       = day;
        it.minute_of_hour     = minute;
        it.humidity_tenths    = hum;
        it.temperature_tenths = 12'(temp);
        it.bypass_press       = bp;
        it.arm_press          = ap;
        return it;
    endfunction

    function automatic cfg_t make_settings(input int thr, input int tl, input int lim,
                                           input int ws, input int hs, input int mi,
                                           input int wc);
        cfg_t c;
        c.moisture_setpoint = 7'(thr);
        c.frost_limit       = 8'(tl);
        c.daily_limit       = 8'(lim);
        c.watering_seconds  = 16'(ws);
        c.holdoff_seconds   = 16'(hs);
        c.measure_interval  = 16'(mi);
        c.water_charge      = 4'(wc);
        return c;
    endfunction

    // mostly a clock that moves forward with a plausible calendar; noisy ticks are raw bits
    function automatic item_t random_item(input bit noisy);
        item_t it;
        int    pick;
        int    t;
        if (noisy)
        begin
            it.now_seconds        = $urandom;
            it.day_of_month       = 5'($urandom);
            it.minute_of_hour     = 6'($urandom);
            it.humidity_tenths    = 10'($urandom);
            it.temperature_tenths = 12'($urandom);
            it.bypass_press       = 1'($urandom);
            it.arm_press          = 1'($urandom);
            return it;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3)
            clock_now = 32'd0;
        else if (pick < 6)
            clock_now = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
        else if (pick < 8)
            clock_now = $urandom;
        else
            clock_now = clock_now + 32'($urandom_range(1, 25));
        it.now_seconds = clock_now;

        pick = $urandom_range(0, 99);
        if (pick < 4)
            clock_day = 5'($urandom_range(1, 31));
        it.day_of_month = (pick >= 4 && pick < 6) ? 5'd0 : clock_day;

        if ($urandom_range(0, 19) == 0)
            it.minute_of_hour = 6'($urandom_range(0, 63));
        else
            it.minute_of_hour = 6'((clock_now / 60) % 60);

        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.humidity_tenths = 10'($urandom_range(0, 500));
        else if (pick < 90)
            it.humidity_tenths = 10'($urandom_range(0, 1000));
        else
            it.humidity_tenths = 10'($urandom_range(1001, 1023));

        if ($urandom_range(0, 99) < 85)
        begin
            t = int'($urandom_range(0, 1650)) - 400;
            it.temperature_tenths = 12'(t);
        end
        else
        begin
            it.temperature_tenths = 12'($urandom);
        end

        it.bypass_press = ($urandom_range(0, 11) == 0);
        it.arm_press    = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    // ready is read at the falling edge so the beat decision is race free
    task automatic send_tick(input item_t it);
        bit seen;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        s_tdata  <= IN_DATA_W'(it);
        s_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
            seen = s_tready;
            @(posedge clk);
        end while (!seen);
        burst_left = burst_left - 1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        bit seen;
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            seen = cfg_ready;
            @(posedge clk);
        end while (!seen);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(REG_MOISTURE_SETPOINT, 16'(c.moisture_setpoint));
        write_reg(REG_FROST_LIMIT, 16'(c.frost_limit));
        write_reg(REG_DAILY_LIMIT, 16'(c.daily_limit));
        write_reg(REG_WATERING_SECONDS, c.watering_seconds);
        write_reg(REG_HOLDOFF_SECONDS, c.holdoff_seconds);
        write_reg(REG_MEASURE_INTERVAL, c.measure_interval);
        write_reg(REG_WATER_CHARGE, 16'(c.water_charge));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cfg_t plan[8];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up settings: threshold out of range, so only bypass opens the valve
        send_tick(make_item(32'd0, 5'd0, 6'd0, 10'd0, 0, 1'b0, 1'b0));
        send_tick(make_item(32'd100, 5'd5, 6'd1, 10'd1000, 1250, 1'b0, 1'b1));
        send_tick(make_item(32'd101, 5'd5, 6'd1, 10'd1023, -2048, 1'b0, 1'b1));
        send_tick(make_item(32'd110, 5'd5, 6'd2, 10'd0, 2047, 1'b1, 1'b0));
        send_tick(make_item(32'd120, 5'd5, 6'd2, 10'd0, 0, 1'b1, 1'b1));
        send_tick(make_item(32'd121, 5'd5, 6'd2, 10'd0, 0, 1'b0, 1'b0));
        send_tick(make_item(32'd130, 5'd5, 6'd59, 10'd300, 200, 1'b1, 1'b0));
        send_tick(make_item(32'd400, 5'd5, 6'd0, 10'd300, -400, 1'b0, 1'b0));
        send_tick(make_item(32'd410, 5'd6, 6'd63, 10'd300, 200, 1'b1, 1'b0));
        send_tick(make_item(32'hFFFF_FFFF, 5'd31, 6'd0, 10'd512, 100, 1'b0, 1'b0));
        // bypass pressed twice at unset time leaves the valve without a deadline
        send_tick(make_item(32'd0, 5'd31, 6'd0, 10'd512, 100, 1'b1, 1'b0));
        send_tick(make_item(32'd0, 5'd31, 6'd0, 10'd512, 100, 1'b1, 1'b0));
        send_tick(make_item(32'd5, 5'd31, 6'd1, 10'd512, 100, 1'b1, 1'b0));
        send_tick(make_item(32'd6, 5'd31, 6'd1, 10'd512, 100, 1'b0, 1'b0));

        // threshold valid, no hold-off, evaluate every tick, short watering
        apply_settings(make_settings(50, -40, 255, 5, 0, 0, 15));
        send_tick(make_item(32'd1000, 5'd3, 6'd10, 10'd500, -400, 1'b0, 1'b0));
        send_tick(make_item(32'd1001, 5'd3, 6'd10, 10'd501, 0, 1'b0, 1'b0));
        send_tick(make_item(32'd1002, 5'd3, 6'd10, 10'd0, -401, 1'b0, 1'b0));
        send_tick(make_item(32'd1003, 5'd3, 6'd10, 10'd0, 0, 1'b0, 1'b0));
        send_tick(make_item(32'd1009, 5'd3, 6'd11, 10'd900, 0, 1'b0, 1'b0));
        // deadline sums that wrap past the top of the time range
        send_tick(make_item(32'hFFFF_FFFB, 5'd3, 6'd12, 10'd0, 0, 1'b0, 1'b0));
        send_tick(make_item(32'hFFFF_FFFC, 5'd3, 6'd12, 10'd0, 0, 1'b0, 1'b0));
        send_tick(make_item(32'd3, 5'd3, 6'd12, 10'd0, 0, 1'b0, 1'b0));

        plan[0] = make_settings(60, 10, 20, 20, 90, 15, 3);
        plan[1] = make_settings(45, -128, 0, 65535, 65535, 65535, 0);
        plan[2] = make_settings(95, 127, 255, 1, 0, 0, 15);
        plan[3] = make_settings(80, -5, 30, 40, 30, 5, 2);
        plan[4] = make_settings(44, 0, 100, 10, 10, 10, 1);
        plan[5] = make_settings(127, -40, 255, 30, 60, 20, 4);
        plan[6] = make_settings($urandom_range(40, 100), $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(1, 100),
                                $urandom_range(0, 200), $urandom_range(0, 40),
                                $urandom_range(0, 15));
        plan[7] = make_settings($urandom_range(45, 95), $urandom_range(0, 20),
                                $urandom_range(0, 60), $urandom_range(1, 60),
                                $urandom_range(0, 100), $urandom_range(0, 20),
                                $urandom_range(0, 15));

        foreach (plan[p])
        begin
            apply_settings(plan[p]);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if (p == 3 && n == PHASE_TICKS / 2)
                    drain_results();
                send_tick(random_item($urandom_range(0, 99) < 15));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
